### src/pdsr_pkg.sv
package pdsr_pkg;

    // Table depth: object positions 1..MAX_OBJECTS
    localparam int MAX_OBJECTS = 7;
    localparam int IDX_W       = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int POS_W       = 3;
    localparam int CODE_W      = 10;
    localparam int ENTRY_W     = 2 * CODE_W;

    // Input item kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_OBJECT  = 2'd1;
    localparam logic [1:0] KIND_REQUEST = 2'd2;
    localparam logic [1:0] KIND_DETACH  = 2'd3;

    // Link phase codes
    localparam logic [1:0] PHASE_IDLE  = 2'd0;
    localparam logic [1:0] PHASE_SENT  = 2'd1;
    localparam logic [1:0] PHASE_READY = 2'd2;

    // Message header fields
    localparam logic [4:0] MSG_SRC_CAPS = 5'd1;
    localparam logic [4:0] MSG_REQUEST  = 5'd2;
    localparam logic [4:0] MSG_PS_RDY   = 5'd6;
    localparam logic [1:0] REV_3_0      = 2'd2;
    localparam int         MV_PER_CODE  = 50;

    // Request header without the message ID, and the fixed RDO flag bits
    localparam logic [31:0] REQ_HDR_BASE = (32'd1 << 12) | (32'(REV_3_0) << 6)
                                         | 32'(MSG_REQUEST);
    localparam logic [31:0] RDO_FLAGS    = (32'd1 << 25) | (32'd1 << 24);

    // One result item
    typedef struct packed {
        logic [31:0]      tx_word;
        logic             tx_valid;
        logic             word_is_header;
        logic             last;
        logic [POS_W-1:0] contract_position;
        logic [1:0]       link_phase;
        logic [POS_W-1:0] fixed_count;
    } result_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SRCH = 4'b0010,
        ST_HDR  = 4'b0100,
        ST_RDO  = 4'b1000
    } state_t;

endpackage

### src/pd_sink_capability_request.sv
// USB PD sink message engine for fixed-supply requests.
// Slave channel: one transaction per received event. s_tuser holds the kind
// (header, data object, request voltage, detach); s_tdata holds rx_word and
// the wanted voltage in mV.
// Master channel: result transactions. Header, data object and detach events
// give one status transaction, pushed to the output queue on acceptance. A
// request gives the Request header and then the fixed RDO (tlast on the RDO).
// A request walks the offer table in block RAM, one read per cycle with the
// compare in the cycle after each read; the first match ends the search, and
// with no match every position is read and position 1 is requested. The
// header and RDO are then pushed as the queue has room, and the slave side is
// ready again once the RDO is pushed and the queue has room. Other events
// are handled on acceptance. One event is worked on at a time.
// Results pass through a two-entry output queue, so a new event is taken
// while a result waits; when the receiver stalls and the queue is full,
// s_tready drops and a request holds before pushing its results.
// Reset clears all counters, the phase and the table valid flags at once;
// no clearing pass is needed and the block is ready as soon as reset ends.
module pd_sink_capability_request
    import pdsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // rx_word[31:0], request_voltage_mv[47:32]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // tx_word[31:0], contract_position[34:32],
                                   // link_phase[36:35], fixed_count[39:37]
    output logic [1:0]  m_tuser,   // tx_valid[0], word_is_header[1]
    output logic        m_tlast
);

    state_t                 state_reg, state_next;
    logic [MAX_OBJECTS-1:0] valid_reg, valid_next;
    logic [POS_W-1:0]       exp_reg, exp_next;
    logic [POS_W-1:0]       seen_reg, seen_next;
    logic [POS_W-1:0]       msg_reg, msg_next;
    logic [1:0]             phase_reg, phase_next;
    logic [POS_W-1:0]       req_reg, req_next;
    logic [POS_W-1:0]       acc_reg, acc_next;
    logic [POS_W-1:0]       fixed_reg, fixed_next;
    logic [POS_W-1:0]       ptr_reg, ptr_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]       chk_pos_reg, chk_pos_next;
    logic [15:0]            mv_reg, mv_next;
    logic [CODE_W-1:0]      cur0_reg, cur0_next;
    logic [CODE_W-1:0]      cur_reg, cur_next;

    logic                   in_xact;
    logic [1:0]             kind;
    logic [31:0]            rx_word;
    logic [15:0]            hdr;
    logic [POS_W-1:0]       nobj;

    logic                   ram_wr_en;
    logic [IDX_W-1:0]       ram_wr_addr;
    logic                   ram_rd_en;
    logic [IDX_W-1:0]       ram_rd_addr;
    logic [ENTRY_W-1:0]     ram_rd_data;
    logic [CODE_W-1:0]      rd_cur;
    logic [15:0]            rd_mv;
    logic                   hit;
    logic [CODE_W-1:0]      cur0_now;

    logic                   push;
    result_t                push_data;
    logic [1:0]             level;
    logic                   q_room;
    result_t                out_data;

    assign kind    = s_tuser;
    assign rx_word = s_tdata[31:0];
    assign hdr     = rx_word[15:0];
    assign nobj    = hdr[14:12];
    assign q_room  = (level != 2'd2);
    assign s_tready = (state_reg == ST_IDLE) && q_room;
    assign in_xact  = s_tvalid && s_tready;

    // Offer table: voltage code in the upper half, current code in the lower
    pdsr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_OBJECTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (rx_word[ENTRY_W-1:0]),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Compare stage of the search
    assign rd_cur   = ram_rd_data[CODE_W-1:0];
    assign rd_mv    = 16'({6'd0, ram_rd_data[ENTRY_W-1:CODE_W]} * 16'(MV_PER_CODE));
    assign hit      = chk_vld_reg && valid_reg[chk_pos_reg] && (rd_mv == mv_reg);
    assign cur0_now = (chk_pos_reg == '0) ? (valid_reg[0] ? rd_cur : '0) : cur0_reg;

    // Sequencer and state update
    always_comb
    begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        exp_next     = exp_reg;
        seen_next    = seen_reg;
        msg_next     = msg_reg;
        phase_next   = phase_reg;
        req_next     = req_reg;
        acc_next     = acc_reg;
        fixed_next   = fixed_reg;
        ptr_next     = ptr_reg;
        chk_vld_next = 1'b0;
        chk_pos_next = chk_pos_reg;
        mv_next      = mv_reg;
        cur0_next    = cur0_reg;
        cur_next     = cur_reg;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = seen_reg[IDX_W-1:0];
        ram_rd_en    = 1'b0;
        ram_rd_addr  = ptr_reg[IDX_W-1:0];
        push         = 1'b0;
        push_data    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xact)
                begin
                    case (kind)
                        KIND_HEADER:
                        begin
                            if (!hdr[15])
                            begin
                                if (nobj != '0)
                                begin
                                    if (hdr[4:0] == MSG_SRC_CAPS)
                                    begin
                                        valid_next = '0;
                                        fixed_next = '0;
                                        exp_next   = (nobj > POS_W'(MAX_OBJECTS))
                                                   ? POS_W'(MAX_OBJECTS) : nobj;
                                        seen_next  = '0;
                                    end
                                end
                                else if (hdr[4:0] == MSG_PS_RDY)
                                begin
                                    if (phase_reg == PHASE_SENT)
                                    begin
                                        phase_next = PHASE_READY;
                                    end
                                    acc_next = req_reg;
                                end
                            end
                        end
                        KIND_OBJECT:
                        begin
                            if (seen_reg < exp_reg)
                            begin
                                seen_next = seen_reg + 1'b1;
                                if (rx_word[31:30] == 2'b00)
                                begin
                                    ram_wr_en                      = 1'b1;
                                    valid_next[seen_reg[IDX_W-1:0]] = 1'b1;
                                    fixed_next                     = fixed_reg + 1'b1;
                                end
                            end
                        end
                        KIND_REQUEST:
                        begin
                            mv_next    = s_tdata[47:32];
                            ptr_next   = '0;
                            state_next = ST_SRCH;
                        end
                        KIND_DETACH:
                        begin
                            valid_next = '0;
                            fixed_next = '0;
                            exp_next   = '0;
                            seen_next  = '0;
                            phase_next = PHASE_IDLE;
                        end
                        default:
                        begin
                        end
                    endcase

                    // Status transaction for every event but a request
                    if (kind != KIND_REQUEST)
                    begin
                        push                        = 1'b1;
                        push_data.last              = 1'b1;
                        push_data.contract_position = acc_next;
                        push_data.link_phase        = phase_next;
                        push_data.fixed_count       = fixed_next;
                    end
                end
            end
            ST_SRCH:
            begin
                // Issue one read per cycle, compare in the next cycle
                if (ptr_reg < POS_W'(MAX_OBJECTS))
                begin
                    ram_rd_en    = 1'b1;
                    chk_vld_next = 1'b1;
                    chk_pos_next = ptr_reg[IDX_W-1:0];
                    ptr_next     = ptr_reg + 1'b1;
                end
                if (chk_vld_reg)
                begin
                    cur0_next = cur0_now;
                    if (hit)
                    begin
                        req_next     = POS_W'(chk_pos_reg) + 1'b1;
                        cur_next     = rd_cur;
                        phase_next   = PHASE_SENT;
                        chk_vld_next = 1'b0;
                        state_next   = ST_HDR;
                    end
                    else if (chk_pos_reg == IDX_W'(MAX_OBJECTS - 1))
                    begin
                        req_next     = POS_W'(1);
                        cur_next     = cur0_now;
                        phase_next   = PHASE_SENT;
                        chk_vld_next = 1'b0;
                        state_next   = ST_HDR;
                    end
                end
            end
            ST_HDR:
            begin
                if (q_room)
                begin
                    push                        = 1'b1;
                    push_data.tx_word           = REQ_HDR_BASE | (32'(msg_reg) << 9);
                    push_data.tx_valid          = 1'b1;
                    push_data.word_is_header    = 1'b1;
                    push_data.contract_position = acc_reg;
                    push_data.link_phase        = phase_reg;
                    push_data.fixed_count       = fixed_reg;
                    msg_next                    = msg_reg + 1'b1;
                    state_next                  = ST_RDO;
                end
            end
            ST_RDO:
            begin
                if (q_room)
                begin
                    push                        = 1'b1;
                    push_data.tx_word           = (32'(req_reg) << 28) | RDO_FLAGS
                                                | (32'(cur_reg) << CODE_W) | 32'(cur_reg);
                    push_data.tx_valid          = 1'b1;
                    push_data.last              = 1'b1;
                    push_data.contract_position = acc_reg;
                    push_data.link_phase        = phase_reg;
                    push_data.fixed_count       = fixed_reg;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and link state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            exp_reg     <= '0;
            seen_reg    <= '0;
            msg_reg     <= '0;
            phase_reg   <= PHASE_IDLE;
            req_reg     <= '0;
            acc_reg     <= '0;
            fixed_reg   <= '0;
            ptr_reg     <= '0;
            chk_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            exp_reg     <= exp_next;
            seen_reg    <= seen_next;
            msg_reg     <= msg_next;
            phase_reg   <= phase_next;
            req_reg     <= req_next;
            acc_reg     <= acc_next;
            fixed_reg   <= fixed_next;
            ptr_reg     <= ptr_next;
            chk_vld_reg <= chk_vld_next;
        end
    end

    // Search payload
    always_ff @(posedge clk)
    begin
        chk_pos_reg <= chk_pos_next;
        mv_reg      <= mv_next;
        cur0_reg    <= cur0_next;
        cur_reg     <= cur_next;
    end

    // Output queue
    pdsr_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .level     (level),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {out_data.fixed_count, out_data.link_phase,
                      out_data.contract_position, out_data.tx_word};
    assign m_tuser = {out_data.word_is_header, out_data.tx_valid};
    assign m_tlast = out_data.last;

    // Checks
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level != 2'd3)
        else $error("output queue overfilled");

    a_fixed_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(fixed_reg))
        else $error("fixed count differs from valid entries");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fixed_reg <= seen_reg) && (seen_reg <= exp_reg))
        else $error("object counters out of order");

    a_req_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HDR) |-> ((req_reg != '0) && (req_reg <= POS_W'(MAX_OBJECTS))))
        else $error("requested position out of range");

    a_msg_step: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_HDR) && q_room) |=> (msg_reg == 3'($past(msg_reg) + 3'd1)))
        else $error("message ID not stepped with header");

endmodule

### src/pdsr_ram.sv
module pdsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

### src/pdsr_out_fifo.sv
module pdsr_out_fifo
    import pdsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  result_t    push_data,
    output logic [1:0] level,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_data
);

    result_t    mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign level     = cnt_reg;

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### test/pd_sink_capability_request_test.sv
module pd_sink_capability_request_test
    import pdsr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // One received event as presented on the slave channel
    typedef struct {
        logic [1:0]  kind;
        logic [31:0] word;
        logic [15:0] mv;
    } pd_event_t;

    localparam int STALL_LIMIT = 2000;
    localparam int REPORT_LIMIT = 10;
    // Typical fixed supply voltages in 50 mV steps: 5 V, 9 V, 15 V, 20 V
    localparam logic [9:0] COMMON_CODES [4] = '{10'd100, 10'd180, 10'd300, 10'd400};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;     // rx_word[31:0], request_voltage_mv[47:32]
    logic [1:0]  s_tuser = KIND_HEADER;  // kind[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // tx_word[31:0], contract_position[34:32],
                                   // link_phase[36:35], fixed_count[39:37]
    logic [1:0]  m_tuser;          // tx_valid[0], word_is_header[1]
    logic        m_tlast;

    pd_event_t event_queue[$];
    pd_event_t next_event;
    result_t   awaited_results[$];
    result_t   got;
    result_t   want;

    int events_made = 0;
    int mismatches = 0;
    int stall_cycles = 0;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;

    // Sink engine state as predicted
    logic [20:0] offers [MAX_OBJECTS];
    logic [2:0]  caps_expected = '0;
    logic [2:0]  caps_seen = '0;
    logic [2:0]  msg_id = '0;
    logic [2:0]  req_pos = '0;
    logic [2:0]  contract_pos = '0;
    logic [2:0]  fixed_cnt = '0;
    logic [1:0]  link_state = PHASE_IDLE;

    pd_sink_capability_request dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic result_t status_now(logic [31:0] w, logic v, logic h, logic l);
        result_t r;
        r.tx_word           = w;
        r.tx_valid          = v;
        r.word_is_header    = h;
        r.last              = l;
        r.contract_position = contract_pos;
        r.link_phase        = link_state;
        r.fixed_count       = fixed_cnt;
        return r;
    endfunction

    task automatic wipe_offers();
        foreach (offers[i])
            offers[i] = '0;
        fixed_cnt = '0;
    endtask

    task automatic pd_engine_step(input logic [1:0] kind, input logic [31:0] word,
                                  input logic [15:0] mv);
        logic [2:0]  n_obj;
        logic [4:0]  hdr_type;
        logic [2:0]  slot;
        int          hit_pos;
        logic [9:0]  cur;
        logic [31:0] req_hdr;
        logic [31:0] rdo;
        n_obj    = word[14:12];
        hdr_type = word[4:0];
        case (kind)
            KIND_HEADER:
                // extended headers are dropped outright
                if (!word[15])
                begin
                    if (n_obj != 0)
                    begin
                        if (hdr_type == MSG_SRC_CAPS)
                        begin
                            wipe_offers();
                            caps_expected = (n_obj > MAX_OBJECTS) ? 3'(MAX_OBJECTS) : n_obj;
                            caps_seen = '0;
                        end
                    end
                    else if (hdr_type == MSG_PS_RDY)
                    begin
                        if (link_state == PHASE_SENT)
                            link_state = PHASE_READY;
                        contract_pos = req_pos;
                    end
                end
            KIND_OBJECT:
                if (caps_seen < caps_expected)
                begin
                    slot = caps_seen;
                    caps_seen = caps_seen + 3'd1;
                    // only fixed supplies are stored, at their own position
                    if (word[31:30] == 2'b00 && slot < MAX_OBJECTS)
                    begin
                        offers[slot] = {1'b1, word[19:0]};
                        fixed_cnt = fixed_cnt + 3'd1;
                    end
                end
            KIND_REQUEST:
            begin
                hit_pos = 0;
                for (int i = 0; i < MAX_OBJECTS; i++)
                    if (hit_pos == 0 && offers[i][20] &&
                        int'(offers[i][19:10]) * MV_PER_CODE == int'(mv))
                        hit_pos = i + 1;
                if (hit_pos == 0)
                    hit_pos = 1;
                req_hdr = {16'h0, 1'b0, 3'd1, msg_id, 1'b0, REV_3_0, 1'b0, MSG_REQUEST};
                msg_id  = msg_id + 3'd1;
                cur     = offers[hit_pos - 1][9:0];
                rdo     = {1'b0, 3'(hit_pos), 2'b00, 1'b1, 1'b1, 4'h0, cur, cur};
                req_pos = 3'(hit_pos);
                link_state = PHASE_SENT;
                awaited_results.push_back(status_now(req_hdr, 1'b1, 1'b1, 1'b0));
                awaited_results.push_back(status_now(rdo, 1'b1, 1'b0, 1'b1));
                return;
            end
            KIND_DETACH:
            begin
                wipe_offers();
                caps_expected = '0;
                caps_seen = '0;
                link_state = PHASE_IDLE;
            end
            default: ;
        endcase
        awaited_results.push_back(status_now(32'h0, 1'b0, 1'b0, 1'b1));
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_event(logic [1:0] kind, logic [31:0] word, logic [15:0] mv);
        pd_event_t e;
        e.kind = kind;
        e.word = word;
        e.mv   = mv;
        event_queue.push_back(e);
        events_made++;
    endtask

    // Header with random spare bits, message ID and roles
    function automatic logic [31:0] header_word(logic ext, logic [2:0] n_obj,
                                                logic [4:0] hdr_type);
        return {16'($urandom), ext, n_obj, 7'($urandom), hdr_type};
    endfunction

    // Capabilities, objects, then requests each usually answered by PS_RDY
    task automatic add_offer_session();
        int          n_off;
        int          n_req;
        logic [9:0]  volts[$];
        logic [9:0]  code;
        logic [15:0] mv;
        n_off = $urandom_range(1, MAX_OBJECTS);
        push_event(KIND_HEADER, header_word(1'b0, 3'(n_off), MSG_SRC_CAPS), 16'($urandom));
        for (int i = 0; i < n_off; i++)
        begin
            if ($urandom_range(99) < 6)
            begin
                push_event(KIND_DETACH, $urandom, 16'($urandom));
                return;
            end
            code = ($urandom_range(2) == 0) ? COMMON_CODES[$urandom_range(3)]
                                            : 10'($urandom);
            if ($urandom_range(99) < 15)
            begin
                push_event(KIND_OBJECT, {2'($urandom_range(1, 3)), 30'($urandom)},
                           16'($urandom));
            end
            else
            begin
                volts.push_back(code);
                push_event(KIND_OBJECT, {2'b00, 10'($urandom), code, 10'($urandom)},
                           16'($urandom));
            end
        end
        if ($urandom_range(99) < 10)
            push_event(KIND_OBJECT, $urandom, 16'($urandom));
        n_req = $urandom_range(1, 3);
        for (int i = 0; i < n_req; i++)
        begin
            if (volts.size() != 0 && $urandom_range(99) < 65)
                mv = 16'(int'(volts[$urandom_range(volts.size() - 1)]) * MV_PER_CODE);
            else if ($urandom_range(1) == 0)
                mv = 16'($urandom);
            else
                mv = 16'(int'(COMMON_CODES[$urandom_range(3)]) * MV_PER_CODE);
            push_event(KIND_REQUEST, $urandom, mv);
            if ($urandom_range(99) < 80)
                push_event(KIND_HEADER, header_word(1'b0, 3'd0, MSG_PS_RDY), 16'($urandom));
        end
        if ($urandom_range(99) < 8)
            push_event(KIND_DETACH, $urandom, 16'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Slave side driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= KIND_HEADER;
        end
        else
        begin
            if (s_tvalid && s_tready)
                pd_engine_step(s_tuser, s_tdata[31:0], s_tdata[47:32]);
            // hold the current transaction until it is taken
            if (!s_tvalid || s_tready)
            begin
                if (event_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    next_event = event_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {next_event.mv, next_event.word};
                    s_tuser  <= next_event.kind;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Master side monitor and checker
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= receiver_idle_pct);
            if (m_tvalid && m_tready)
            begin
                got.tx_word           = m_tdata[31:0];
                got.contract_position = m_tdata[34:32];
                got.link_phase        = m_tdata[36:35];
                got.fixed_count       = m_tdata[39:37];
                got.tx_valid          = m_tuser[0];
                got.word_is_header    = m_tuser[1];
                got.last              = m_tlast;
                if (awaited_results.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("%0t: unexpected result word=%h user=%b last=%b",
                                 $realtime, m_tdata[31:0], m_tuser, m_tlast);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.tx_word !== want.tx_word || got.tx_valid !== want.tx_valid ||
                        got.word_is_header !== want.word_is_header ||
                        got.last !== want.last ||
                        got.contract_position !== want.contract_position ||
                        got.link_phase !== want.link_phase ||
                        got.fixed_count !== want.fixed_count)
                    begin
                        if (mismatches < REPORT_LIMIT)
                        begin
                            $display("%0t: expected word=%h v=%b h=%b l=%b pos=%0d ph=%0d n=%0d",
                                     $realtime, want.tx_word, want.tx_valid,
                                     want.word_is_header, want.last,
                                     want.contract_position, want.link_phase,
                                     want.fixed_count);
                            $display("%0t:   actual word=%h v=%b h=%b l=%b pos=%0d ph=%0d n=%0d",
                                     $realtime, got.tx_word, got.tx_valid,
                                     got.word_is_header, got.last,
                                     got.contract_position, got.link_phase,
                                     got.fixed_count);
                        end
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog: cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL pd_sink_capability_request");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial
    begin
        int target;
        foreach (offers[i])
            offers[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0:
                begin
                    sender_idle_pct = 6;
                    receiver_idle_pct = 57;
                end
                1:
                begin
                    sender_idle_pct = 57;
                    receiver_idle_pct = 6;
                end
                default:
                begin
                    sender_idle_pct = 0;
                    receiver_idle_pct = 0;
                end
            endcase

            if (p == 0)
            begin
                // PS_RDY with no request outstanding, then requests on an empty table
                push_event(KIND_HEADER, 32'h0000_0006, 16'h0000);
                push_event(KIND_REQUEST, 32'hFFFF_FFFF, 16'hFFFF);
                push_event(KIND_REQUEST, 32'h0000_0000, 16'h0000);
                push_event(KIND_HEADER, 32'hFFFF_0FE6, 16'hFFFF);
                // full capabilities: non-fixed, max codes, zero codes, non-fixed, 5/9/20 V
                push_event(KIND_HEADER, 32'hFFFF_7FE1, 16'h0000);
                push_event(KIND_OBJECT, 32'hFFFF_FFFF, 16'hFFFF);
                push_event(KIND_OBJECT, 32'h3FFF_FFFF, 16'h0000);
                push_event(KIND_OBJECT, 32'h0000_0000, 16'hFFFF);
                push_event(KIND_OBJECT, 32'h4001_912C, 16'h0000);
                push_event(KIND_OBJECT, {12'h000, 10'd100, 10'd300}, 16'h0000);
                push_event(KIND_OBJECT, {12'h000, 10'd180, 10'd222}, 16'h0000);
                push_event(KIND_OBJECT, {12'h0A5, 10'd400, 10'd500}, 16'h0000);
                // surplus object, extended header, other data and control types
                push_event(KIND_OBJECT, {12'h000, 10'd300, 10'd100}, 16'h0000);
                push_event(KIND_HEADER, 32'h0000_F001, 16'h0000);
                push_event(KIND_HEADER, 32'h0000_2005, 16'h0000);
                push_event(KIND_HEADER, 32'h0000_0003, 16'h0000);
                push_event(KIND_HEADER, 32'h0000_0001, 16'h0000);
                // exact match, top code, zero volts, no match onto an empty position 1
                push_event(KIND_REQUEST, 32'h0, 16'd9000);
                push_event(KIND_REQUEST, 32'h0, 16'd51150);
                push_event(KIND_REQUEST, 32'h0, 16'd0);
                push_event(KIND_REQUEST, 32'h0, 16'd12345);
                push_event(KIND_HEADER, 32'h0000_0006, 16'h0000);
                // detach, then PS_RDY while idle
                push_event(KIND_DETACH, 32'hA5A5_5A5A, 16'hFFFF);
                push_event(KIND_HEADER, 32'h0000_0006, 16'h0000);
                push_event(KIND_REQUEST, 32'h0, 16'd20000);
            end

            target = 150 * (p + 1);
            while (events_made < target)
            begin
                if ($urandom_range(99) < 15)
                    push_event(2'($urandom), $urandom, 16'($urandom));
                else
                    add_offer_session();
            end

            while (event_queue.size() != 0 || s_tvalid)
                @(posedge clk);
        end

        // drain outstanding results, then allow for late extras
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0 && awaited_results.size() == 0)
            $display("PASS pd_sink_capability_request");
        else
            $display("FAIL pd_sink_capability_request");
        $finish;
    end

endmodule
